[rtl/awu_pkg.sv]
// Shared types and constants of the Adam weight update engine.
// Used by every module under rtl; depends on nothing else.

package awu_pkg;

    localparam int IDX_W      = 10;
    localparam int NUM_PARAMS = 1024;
    localparam int MAX_BATCH  = 16;

    // Q1.31 constants
    localparam logic [31:0] ONE_Q31  = 32'h8000_0000;
    localparam logic [31:0] B1_Q31   = 32'd1932735283;
    localparam logic [31:0] C1_Q31   = 32'd214748365;
    localparam logic [31:0] B2_Q31   = 32'd2145336164;
    localparam logic [31:0] C2_Q31   = 32'd2147484;
    localparam logic [63:0] HALF_Q31 = 64'd1073741824;
    localparam logic [47:0] MASK48   = 48'hFFFF_FFFF_FFFF;

    // register index, taken from paddr[2]
    localparam logic REG_LR   = 1'b0;
    localparam logic REG_CLIP = 1'b1;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_LOAD,
        S_PW1, S_PW1W, S_PW2, S_PW2W,
        S_GDIV, S_GDIVW, S_GSQ, S_GSQW,
        S_MUPD, S_MUPDW, S_VUPD, S_VUPDW, S_WB,
        S_MHAT, S_MHATW, S_VHAT, S_VHATW,
        S_SQRT, S_SQRTW, S_NUM, S_NUMW,
        S_STEP, S_STEPW, S_FIN
    } state_t;

endpackage

[rtl/awu_mac.sv]
// Multi-cycle multiply-accumulate: a (64 bit) * b (32 bit) + addend.
// One 24 x 32 multiplier, three chunks of a; uses awu_pkg.

module awu_mac (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [63:0]         a,
    input  logic [31:0]         b,
    input  logic [63:0]         addend,
    output awu_pkg::unit_stat_t stat,
    output logic [96:0]         acc
);

    logic [63:0] a_reg;
    logic [31:0] b_reg;
    logic [96:0] acc_reg;
    logic [96:0] acc_next;
    logic [1:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [23:0] chunk;
    logic [55:0] prod;

    always_comb
    begin
        case (cnt_reg)
            2'd0:    chunk = a_reg[23:0];
            2'd1:    chunk = a_reg[47:24];
            default: chunk = {8'b0, a_reg[63:48]};
        endcase
        prod = 56'(chunk) * 56'(b_reg);
        case (cnt_reg)
            2'd0:    acc_next = acc_reg + {41'b0, prod};
            2'd1:    acc_next = acc_reg + {17'b0, prod, 24'b0};
            default: acc_next = acc_reg + {prod[48:0], 48'b0};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 2'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 2'd1;
                if (cnt_reg == 2'd2)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= {33'b0, addend};
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign acc       = acc_reg;

endmodule

[rtl/awu_div.sv]
// Restoring divider, one quotient bit a cycle, MSB-aligned dividend.
// Keeps the low 64 quotient bits; uses awu_pkg.

module awu_div (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [95:0]         dividend,
    input  logic [6:0]          steps,
    input  logic [32:0]         den,
    output awu_pkg::unit_stat_t stat,
    output logic [63:0]         quot
);

    logic [95:0] dvd_reg;
    logic [33:0] rem_reg;
    logic [32:0] den_reg;
    logic [63:0] q_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [33:0] rem_sh;
    logic        fits;

    always_comb
    begin
        rem_sh = {rem_reg[32:0], dvd_reg[95]};
        fits   = (rem_sh >= {1'b0, den_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 7'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= steps;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            den_reg <= den;
            rem_reg <= 34'd0;
            q_reg   <= 64'd0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[94:0], 1'b0};
            rem_reg <= fits ? (rem_sh - {1'b0, den_reg}) : rem_sh;
            q_reg   <= {q_reg[62:0], fits};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = q_reg;

endmodule

[rtl/awu_sqrt.sv]
// Integer square root of a 64-bit word, two radicand bits a cycle.
// 32 iterations; uses awu_pkg.

module awu_sqrt (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [63:0]         x,
    output awu_pkg::unit_stat_t stat,
    output logic [31:0]         root
);

    logic [63:0] x_reg;
    logic [63:0] res_reg;
    logic [63:0] bit_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [63:0] trial;

    assign trial = res_reg + bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd31;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= x;
            res_reg <= 64'd0;
            bit_reg <= 64'h4000_0000_0000_0000;
        end
        else if (busy_reg)
        begin
            if (x_reg >= trial)
            begin
                x_reg   <= x_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign root      = res_reg[31:0];

endmodule

[rtl/adam_weight_update_core.sv]
// Adam weight update engine: sequencer, moment memories, config registers.
// Uses awu_pkg, awu_mac, awu_div and awu_sqrt.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------
//  in      | to block  | in_valid/in_stall  | param_index grad_sum sample_count
//          |           |                    | current_weight start_flush skip_update
//  out     | from block| out_valid/out_stall| out_index new_weight
//  apb     | to block  | psel/penable/pready| paddr pwrite pwdata prdata
//
// A full update is dominated by the bit-serial divider: four divisions
// of 32, 63, 79 and 64 steps, plus a 32-step square root and the multiplies.
// A zero count or unflushed frozen column skips to finish; a flush adds two multiplies.
// After reset a pass over all 1024 entries zeroes the moment memories; in_stall is high.
// in_stall is low only while idle; a finished word waits in the output register,
// and the next word is taken meanwhile.

module adam_weight_update_core (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [awu_pkg::IDX_W-1:0] param_index,
    input  logic signed [31:0]        grad_sum,
    input  logic [4:0]                sample_count,
    input  logic signed [31:0]        current_weight,
    input  logic                      start_flush,
    input  logic                      skip_update,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [awu_pkg::IDX_W-1:0] out_index,
    output logic signed [31:0]        new_weight,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [2:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    localparam logic [6:0] G_STEPS    = 7'd32;
    localparam logic [6:0] MHAT_STEPS = 7'd63;
    localparam logic [6:0] VHAT_STEPS = 7'd79;
    localparam logic [6:0] STEP_STEPS = 7'd64;

    awu_pkg::state_t state_reg, state_next;

    logic [awu_pkg::IDX_W-1:0] clr_reg;
    logic [15:0] lr_reg;
    logic [30:0] clip_reg;
    logic [31:0] beta1_reg;
    logic [31:0] beta2_reg;

    logic [awu_pkg::IDX_W-1:0] idx_reg;
    logic [31:0] gsum_reg;
    logic [31:0] w_reg;
    logic [4:0]  cnt_reg;
    logic        flush_reg;
    logic        skip_reg;
    logic [31:0] m_rd_reg;
    logic [47:0] v_rd_reg;
    logic [32:0] g_reg;
    logic [47:0] g2_reg;
    logic [33:0] d_reg;
    logic [31:0] m_reg;
    logic [47:0] v_reg;
    logic [63:0] mhat_reg;
    logic [63:0] vhat_reg;
    logic [32:0] den_reg;
    logic [63:0] numer_reg;
    logic [65:0] res_reg;

    logic        out_valid_reg;
    logic [awu_pkg::IDX_W-1:0] out_index_reg;
    logic [31:0] out_weight_reg;

    logic [31:0] fm_mem [awu_pkg::NUM_PARAMS];
    logic [47:0] sm_mem [awu_pkg::NUM_PARAMS];

    logic        accept;
    logic        cfg_write;
    logic [4:0]  cnt_sat;

    logic        mac_start;
    logic [63:0] mac_a;
    logic [31:0] mac_b;
    logic [63:0] mac_add;
    logic [96:0] mac_acc;
    awu_pkg::unit_stat_t mac_stat;

    logic        div_start;
    logic [95:0] div_dvd;
    logic [6:0]  div_steps;
    logic [32:0] div_den;
    logic [63:0] div_q;
    awu_pkg::unit_stat_t div_stat;

    logic        sqrt_start;
    logic [31:0] sqrt_root;
    awu_pkg::unit_stat_t sqrt_stat;

    logic        mem_we;
    logic [awu_pkg::IDX_W-1:0] mem_waddr;
    logic [31:0] mem_wm;
    logic [47:0] mem_wv;

    logic [31:0] gmag;
    logic [31:0] gabs;
    logic [33:0] dabs;
    logic [31:0] mabs;
    logic        g2_ge_v;
    logic [47:0] vdiff;
    logic [31:0] d1;
    logic [31:0] d2;
    logic        corr_ok;
    logic [49:0] frac_res;
    logic [50:0] m_sum;
    logic [31:0] m_sat;
    logic [65:0] pos_clip;
    logic [65:0] neg_clip;
    logic [31:0] final_weight;
    logic        do_clamp;
    logic        fin_go;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != awu_pkg::S_IDLE);
    assign cfg_write = psel && penable && pwrite && pready;
    assign cnt_sat   = (sample_count > 5'(awu_pkg::MAX_BATCH))
                       ? 5'(awu_pkg::MAX_BATCH) : sample_count;

    // datapath helpers
    always_comb
    begin
        gmag     = gsum_reg[31] ? (32'd0 - gsum_reg) : gsum_reg;
        gabs     = g_reg[32] ? 32'(33'd0 - g_reg) : g_reg[31:0];
        dabs     = d_reg[33] ? (34'd0 - d_reg) : d_reg;
        mabs     = m_reg[31] ? (32'd0 - m_reg) : m_reg;
        g2_ge_v  = (g2_reg >= v_rd_reg);
        vdiff    = g2_ge_v ? (g2_reg - v_rd_reg) : (v_rd_reg - g2_reg);
        d1       = awu_pkg::ONE_Q31 - beta1_reg;
        d2       = awu_pkg::ONE_Q31 - beta2_reg;
        corr_ok  = (d1 != 32'd0) && (d2 != 32'd0);
        frac_res = mac_acc[80:31];
        m_sum    = d_reg[33] ? ({{19{m_rd_reg[31]}}, m_rd_reg} - {1'b0, frac_res})
                             : ({{19{m_rd_reg[31]}}, m_rd_reg} + {1'b0, frac_res});
        // saturate to the 32-bit range
        if (m_sum[50:31] == {20{m_sum[50]}})
            m_sat = m_sum[31:0];
        else
            m_sat = m_sum[50] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        pos_clip = {35'b0, clip_reg};
        neg_clip = 66'd0 - pos_clip;
        do_clamp = (cnt_reg != 5'd0) && !skip_reg;
        if (do_clamp && ($signed(res_reg) > $signed(pos_clip)))
            final_weight = pos_clip[31:0];
        else if (do_clamp && ($signed(res_reg) < $signed(neg_clip)))
            final_weight = neg_clip[31:0];
        else
            final_weight = res_reg[31:0];
        fin_go = !out_valid_reg || !out_stall;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            awu_pkg::S_CLEAR:
                if (clr_reg == awu_pkg::IDX_W'(awu_pkg::NUM_PARAMS - 1))
                    state_next = awu_pkg::S_IDLE;
            awu_pkg::S_IDLE:
                if (accept) state_next = awu_pkg::S_LOAD;
            awu_pkg::S_LOAD:
                if (cnt_reg == 5'd0)  state_next = awu_pkg::S_FIN;
                else if (flush_reg)   state_next = awu_pkg::S_PW1;
                else if (skip_reg)    state_next = awu_pkg::S_FIN;
                else                  state_next = awu_pkg::S_GDIV;
            awu_pkg::S_PW1:   state_next = awu_pkg::S_PW1W;
            awu_pkg::S_PW1W:  if (mac_stat.done) state_next = awu_pkg::S_PW2;
            awu_pkg::S_PW2:   state_next = awu_pkg::S_PW2W;
            awu_pkg::S_PW2W:
                if (mac_stat.done)
                    state_next = skip_reg ? awu_pkg::S_FIN : awu_pkg::S_GDIV;
            awu_pkg::S_GDIV:  state_next = awu_pkg::S_GDIVW;
            awu_pkg::S_GDIVW: if (div_stat.done) state_next = awu_pkg::S_GSQ;
            awu_pkg::S_GSQ:   state_next = awu_pkg::S_GSQW;
            awu_pkg::S_GSQW:  if (mac_stat.done) state_next = awu_pkg::S_MUPD;
            awu_pkg::S_MUPD:  state_next = awu_pkg::S_MUPDW;
            awu_pkg::S_MUPDW: if (mac_stat.done) state_next = awu_pkg::S_VUPD;
            awu_pkg::S_VUPD:  state_next = awu_pkg::S_VUPDW;
            awu_pkg::S_VUPDW: if (mac_stat.done) state_next = awu_pkg::S_WB;
            awu_pkg::S_WB:
                state_next = corr_ok ? awu_pkg::S_MHAT : awu_pkg::S_FIN;
            awu_pkg::S_MHAT:  state_next = awu_pkg::S_MHATW;
            awu_pkg::S_MHATW: if (div_stat.done) state_next = awu_pkg::S_VHAT;
            awu_pkg::S_VHAT:  state_next = awu_pkg::S_VHATW;
            awu_pkg::S_VHATW: if (div_stat.done) state_next = awu_pkg::S_SQRT;
            awu_pkg::S_SQRT:  state_next = awu_pkg::S_SQRTW;
            awu_pkg::S_SQRTW: if (sqrt_stat.done) state_next = awu_pkg::S_NUM;
            awu_pkg::S_NUM:   state_next = awu_pkg::S_NUMW;
            awu_pkg::S_NUMW:  if (mac_stat.done) state_next = awu_pkg::S_STEP;
            awu_pkg::S_STEP:  state_next = awu_pkg::S_STEPW;
            awu_pkg::S_STEPW: if (div_stat.done) state_next = awu_pkg::S_FIN;
            awu_pkg::S_FIN:   if (fin_go) state_next = awu_pkg::S_IDLE;
            default:          state_next = awu_pkg::S_IDLE;
        endcase
    end

    // unit operands and memory write port
    always_comb
    begin
        mac_start  = 1'b0;
        mac_a      = 64'd0;
        mac_b      = 32'd0;
        mac_add    = awu_pkg::HALF_Q31;
        div_start  = 1'b0;
        div_dvd    = {numer_reg, 32'b0};
        div_steps  = STEP_STEPS;
        div_den    = den_reg;
        sqrt_start = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = idx_reg;
        mem_wm     = m_reg;
        mem_wv     = v_reg;
        unique case (state_reg)
            awu_pkg::S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wm    = 32'd0;
                mem_wv    = 48'd0;
            end
            awu_pkg::S_PW1:
            begin
                mac_start = 1'b1;
                mac_a     = {32'b0, beta1_reg};
                mac_b     = awu_pkg::B1_Q31;
            end
            awu_pkg::S_PW2:
            begin
                mac_start = 1'b1;
                mac_a     = {32'b0, beta2_reg};
                mac_b     = awu_pkg::B2_Q31;
            end
            awu_pkg::S_GDIV:
            begin
                div_start = 1'b1;
                div_dvd   = {gmag, 64'b0};
                div_steps = G_STEPS;
                div_den   = {28'b0, cnt_reg};
            end
            awu_pkg::S_GSQ:
            begin
                mac_start = 1'b1;
                mac_a     = {32'b0, gabs};
                mac_b     = gabs;
                mac_add   = 64'd0;
            end
            awu_pkg::S_MUPD:
            begin
                mac_start = 1'b1;
                mac_a     = {30'b0, dabs};
                mac_b     = awu_pkg::C1_Q31;
            end
            awu_pkg::S_VUPD:
            begin
                mac_start = 1'b1;
                mac_a     = {16'b0, vdiff};
                mac_b     = awu_pkg::C2_Q31;
            end
            awu_pkg::S_WB:
                mem_we = 1'b1;
            awu_pkg::S_MHAT:
            begin
                div_start = 1'b1;
                div_dvd   = {mabs, 64'b0};
                div_steps = MHAT_STEPS;
                div_den   = {1'b0, d1};
            end
            awu_pkg::S_VHAT:
            begin
                div_start = 1'b1;
                div_dvd   = {v_reg, 48'b0};
                div_steps = VHAT_STEPS;
                div_den   = {1'b0, d2};
            end
            awu_pkg::S_SQRT:
                sqrt_start = 1'b1;
            awu_pkg::S_NUM:
            begin
                mac_start = 1'b1;
                mac_a     = mhat_reg;
                mac_b     = {16'b0, lr_reg};
                mac_add   = {32'b0, den_reg[32:1]};
            end
            awu_pkg::S_STEP:
                div_start = 1'b1;
            default:
            begin
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= awu_pkg::S_CLEAR;
            clr_reg       <= '0;
            lr_reg        <= 16'd655;
            clip_reg      <= 31'd327680;
            beta1_reg     <= awu_pkg::ONE_Q31;
            beta2_reg     <= awu_pkg::ONE_Q31;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == awu_pkg::S_CLEAR)
                clr_reg <= clr_reg + awu_pkg::IDX_W'(1);
            if (cfg_write)
            begin
                if (paddr[2] == awu_pkg::REG_LR)
                    lr_reg <= pwdata[15:0];
                else
                    clip_reg <= pwdata[30:0];
            end
            if (state_reg == awu_pkg::S_PW1W && mac_stat.done)
                beta1_reg <= mac_acc[62:31];
            if (state_reg == awu_pkg::S_PW2W && mac_stat.done)
                beta2_reg <= mac_acc[62:31];
            if (state_reg == awu_pkg::S_FIN && fin_go)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            idx_reg   <= param_index;
            gsum_reg  <= grad_sum;
            w_reg     <= current_weight;
            cnt_reg   <= cnt_sat;
            flush_reg <= start_flush;
            skip_reg  <= skip_update;
            res_reg   <= {{34{current_weight[31]}}, current_weight};
        end
        unique case (state_reg)
            awu_pkg::S_GDIVW:
                if (div_stat.done)
                    g_reg <= gsum_reg[31] ? (33'd0 - {1'b0, div_q[31:0]})
                                          : {1'b0, div_q[31:0]};
            awu_pkg::S_GSQW:
                if (mac_stat.done)
                begin
                    g2_reg <= (mac_acc[96:48] != '0) ? awu_pkg::MASK48 : mac_acc[47:0];
                    d_reg  <= {g_reg[32], g_reg} - {{2{m_rd_reg[31]}}, m_rd_reg};
                end
            awu_pkg::S_MUPDW:
                if (mac_stat.done) m_reg <= m_sat;
            awu_pkg::S_VUPDW:
                if (mac_stat.done)
                    v_reg <= g2_ge_v ? (v_rd_reg + frac_res[47:0])
                                     : (v_rd_reg - frac_res[47:0]);
            awu_pkg::S_MHATW:
                if (div_stat.done) mhat_reg <= div_q;
            awu_pkg::S_VHATW:
                if (div_stat.done) vhat_reg <= div_q;
            awu_pkg::S_SQRTW:
                if (sqrt_stat.done) den_reg <= {1'b0, sqrt_root} + 33'd1;
            awu_pkg::S_NUMW:
                if (mac_stat.done) numer_reg <= mac_acc[63:0];
            awu_pkg::S_STEPW:
                if (div_stat.done)
                    res_reg <= m_reg[31]
                        ? ({{34{w_reg[31]}}, w_reg} + {2'b0, div_q})
                        : ({{34{w_reg[31]}}, w_reg} - {2'b0, div_q});
            default:
            begin
            end
        endcase
        if (state_reg == awu_pkg::S_FIN && fin_go)
        begin
            out_index_reg  <= idx_reg;
            out_weight_reg <= final_weight;
        end
    end

    // moment memories
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            fm_mem[mem_waddr] <= mem_wm;
            sm_mem[mem_waddr] <= mem_wv;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            m_rd_reg <= fm_mem[param_index];
            v_rd_reg <= sm_mem[param_index];
        end
    end

    awu_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mac_start),
        .a      (mac_a),
        .b      (mac_b),
        .addend (mac_add),
        .stat   (mac_stat),
        .acc    (mac_acc)
    );

    awu_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .steps    (div_steps),
        .den      (div_den),
        .stat     (div_stat),
        .quot     (div_q)
    );

    awu_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .x     (vhat_reg),
        .stat  (sqrt_stat),
        .root  (sqrt_root)
    );

    assign out_valid  = out_valid_reg;
    assign out_index  = out_index_reg;
    assign new_weight = out_weight_reg;
    assign pready     = 1'b1;
    assign prdata     = (paddr[2] == awu_pkg::REG_CLIP) ? {1'b0, clip_reg} : {16'b0, lr_reg};

    a_beta_range: assert property (@(posedge clk) disable iff (!rst_n)
        beta1_reg <= awu_pkg::ONE_Q31 && beta2_reg <= awu_pkg::ONE_Q31)
        else $error("beta power above one");

    a_units_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> !mac_stat.busy && !div_stat.busy && !sqrt_stat.busy)
        else $error("word taken while a unit is busy");

    a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == awu_pkg::S_FIN))
        else $error("result raised outside finish state");

endmodule
